// File: hw/rtl/etu_pkg.sv
// ----------------------------------------------------------------------------
// etu_pkg
// shared types, character codes and classifier functions for the
// expression tokenizer
// ----------------------------------------------------------------------------
package etu_pkg;

  localparam int CH_W              = 8;
  localparam int VAL_W             = 32;
  localparam int LEN_W             = 7;
  localparam int KIND_W            = 3;
  localparam int MAX_IDENT_LEN_DEF = 79;
  localparam int FIFO_DEPTH        = 4;

  localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_W-1:0] CH_LT    = 8'h3c;
  localparam logic [CH_W-1:0] CH_EQ    = 8'h3d;
  localparam logic [CH_W-1:0] CH_GT    = 8'h3e;
  localparam logic [CH_W-1:0] CH_UNDER = 8'h5f;
  localparam logic [CH_W-1:0] CH_LOW_X = 8'h78;
  localparam logic [CH_W-1:0] CH_TILDE = 8'h7e;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_IDENT,
    MODE_DEC,
    MODE_ZERO,
    MODE_HEX,
    MODE_LT,
    MODE_GT,
    MODE_TILDE
  } mode_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_EOF,
    KIND_ID,
    KIND_INT,
    KIND_LE,
    KIND_GE,
    KIND_NE,
    KIND_CHAR
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [VAL_W-1:0]  value;
    logic              last;
  } tok_t;

  function automatic logic is_letter(input logic [CH_W-1:0] c);
    return c inside {[8'h61:8'h7a], [8'h41:8'h5a]};
  endfunction

  function automatic logic is_digit(input logic [CH_W-1:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_hex(input logic [CH_W-1:0] c);
    return c inside {[8'h30:8'h39], [8'h61:8'h66], [8'h41:8'h46]};
  endfunction

  // nibble value of a hex digit, only meaningful when is_hex is true
  function automatic logic [3:0] hex_val(input logic [CH_W-1:0] c);
    logic [3:0] v;
    if (is_digit(c)) begin
      v = c[3:0];
    end else begin
      v = c[3:0] + 4'd9;
    end
    return v;
  endfunction

endpackage

// File: hw/rtl/etu_if.sv
// ----------------------------------------------------------------------------
// etu_if
// valid/ready channels of the expression tokenizer: character beats in,
// token beats out
// ----------------------------------------------------------------------------
interface etu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_line;

  modport source (output valid, ch, end_of_line, input ready);
  modport sink   (input valid, ch, end_of_line, output ready);
endinterface

interface etu_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  token_kind;
  logic [31:0] token_value;
  logic        last;

  modport source (output valid, token_kind, token_value, last, input ready);
  modport sink   (input valid, token_kind, token_value, last, output ready);
endinterface

// File: hw/rtl/etu_scan.sv
// ----------------------------------------------------------------------------
// etu_scan
// scanner state and per-character token logic; produces up to two tokens
// for each character or end-of-line mark
// ----------------------------------------------------------------------------
module etu_scan import etu_pkg::*; #(
  parameter int MAX_IDENT_LEN = MAX_IDENT_LEN_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            fire,
  input  logic [CH_W-1:0] ch,
  input  logic            eol,
  output logic [1:0]      res_n,
  output tok_t            res0,
  output tok_t            res1
);

  mode_t             mode_r, mode_nxt;
  logic [VAL_W-1:0]  acc_r, acc_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;

  logic  pend_vld;
  tok_t  pend_tok;
  logic  consumed;
  logic  rel_vld;
  kind_t rel_kind;
  logic  flush_vld;
  logic  char_vld;
  tok_t  rel_tok;
  tok_t  char_tok;
  tok_t  eof_tok;

  // pending token
  always_comb begin
    pend_vld = 1'b1;
    pend_tok = '{kind: KIND_INT, value: '0, last: 1'b0};
    case (mode_r)
      MODE_IDENT: pend_tok = '{kind: KIND_ID, value: VAL_W'(len_r), last: 1'b0};
      MODE_DEC,
      MODE_HEX:   pend_tok = '{kind: KIND_INT, value: acc_r, last: 1'b0};
      MODE_ZERO:  pend_tok = '{kind: KIND_INT, value: '0, last: 1'b0};
      MODE_LT:    pend_tok = '{kind: KIND_CHAR, value: VAL_W'(CH_LT), last: 1'b0};
      MODE_GT:    pend_tok = '{kind: KIND_CHAR, value: VAL_W'(CH_GT), last: 1'b0};
      MODE_TILDE: pend_tok = '{kind: KIND_CHAR, value: VAL_W'(CH_TILDE), last: 1'b0};
      default:    pend_vld = 1'b0;
    endcase
  end

  always_comb begin
    mode_nxt = mode_r;
    acc_nxt  = acc_r;
    len_nxt  = len_r;
    consumed = 1'b0;
    rel_vld  = 1'b0;
    rel_kind = KIND_LE;
    char_vld = 1'b0;

    if (!eol) begin
      case (mode_r)
        MODE_IDENT: begin
          if (is_letter(ch) || is_digit(ch) || ch == CH_UNDER) begin
            consumed = 1'b1;
            if (len_r < LEN_W'(MAX_IDENT_LEN)) begin
              len_nxt = len_r + 1'b1;
            end
          end
        end
        MODE_DEC: begin
          if (is_digit(ch)) begin
            consumed = 1'b1;
            acc_nxt  = (acc_r << 3) + (acc_r << 1) + VAL_W'(ch[3:0]);
          end
        end
        MODE_ZERO: begin
          if (ch == CH_LOW_X) begin
            consumed = 1'b1;
            mode_nxt = MODE_HEX;
            acc_nxt  = '0;
          end else if (is_digit(ch)) begin
            consumed = 1'b1;
            mode_nxt = MODE_DEC;
            acc_nxt  = VAL_W'(ch[3:0]);
          end
        end
        MODE_HEX: begin
          if (is_hex(ch)) begin
            consumed = 1'b1;
            acc_nxt  = {acc_r[VAL_W-5:0], hex_val(ch)};
          end
        end
        MODE_LT, MODE_GT, MODE_TILDE: begin
          if (ch == CH_EQ) begin
            consumed = 1'b1;
            rel_vld  = 1'b1;
            mode_nxt = MODE_IDLE;
            if (mode_r == MODE_LT) begin
              rel_kind = KIND_LE;
            end else if (mode_r == MODE_GT) begin
              rel_kind = KIND_GE;
            end else begin
              rel_kind = KIND_NE;
            end
          end
        end
        default: ;
      endcase
    end

    flush_vld = pend_vld && (eol || !consumed);

    if (eol) begin
      mode_nxt = MODE_IDLE;
    end else if (!consumed) begin
      mode_nxt = MODE_IDLE;
      if (ch == CH_SPACE || ch == CH_TAB) begin
        mode_nxt = MODE_IDLE;
      end else if (is_letter(ch)) begin
        mode_nxt = MODE_IDENT;
        len_nxt  = LEN_W'(1);
      end else if (ch == CH_ZERO) begin
        mode_nxt = MODE_ZERO;
        acc_nxt  = '0;
      end else if (is_digit(ch)) begin
        mode_nxt = MODE_DEC;
        acc_nxt  = VAL_W'(ch[3:0]);
      end else if (ch == CH_LT) begin
        mode_nxt = MODE_LT;
      end else if (ch == CH_GT) begin
        mode_nxt = MODE_GT;
      end else if (ch == CH_TILDE) begin
        mode_nxt = MODE_TILDE;
      end else begin
        char_vld = 1'b1;
      end
    end
  end

  // result ordering: flushed token first, then the token of this beat
  always_comb begin
    rel_tok  = '{kind: rel_kind, value: '0, last: 1'b0};
    char_tok = '{kind: KIND_CHAR, value: VAL_W'(ch), last: 1'b0};
    eof_tok  = '{kind: KIND_EOF, value: '0, last: 1'b0};
    res_n    = 2'(flush_vld) + 2'(rel_vld || char_vld || eol);
    if (flush_vld) begin
      res0 = pend_tok;
    end else if (rel_vld) begin
      res0 = rel_tok;
    end else if (char_vld) begin
      res0 = char_tok;
    end else begin
      res0 = eof_tok;
    end
    res1      = char_vld ? char_tok : eof_tok;
    res0.last = (res_n == 2'd1);
    res1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      acc_r  <= '0;
      len_r  <= '0;
    end else if (fire) begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
      len_r  <= len_nxt;
    end
  end

  a_idle_single: assert property (@(posedge clk) disable iff (!rst_n)
    fire && mode_r == MODE_IDLE && !eol |-> res_n <= 2'd1)
    else $error("idle scanner produced two tokens from one character");

  a_eol_emits: assert property (@(posedge clk) disable iff (!rst_n)
    fire && eol |=> mode_r == MODE_IDLE)
    else $error("scanner not idle after end of line");

  a_res_n_range: assert property (@(posedge clk) disable iff (!rst_n)
    fire |-> res_n != 2'd3)
    else $error("scanner produced more than two tokens");

endmodule

// File: hw/rtl/etu_fifo.sv
// ----------------------------------------------------------------------------
// etu_fifo
// token result queue; takes up to two tokens per cycle, delivers one beat
// per cycle while ready is high on the output channel
// ----------------------------------------------------------------------------
module etu_fifo import etu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [1:0]  push_n,
  input  tok_t        push0,
  input  tok_t        push1,
  output logic        room2,
  etu_out_if.source   out_chan
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  tok_t             mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] wr_ptr_p1;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             pop;
  tok_t             head;

  assign head      = mem_r[rd_ptr_r];
  assign pop       = out_chan.valid && out_chan.ready;
  assign room2     = cnt_r <= CNT_W'(FIFO_DEPTH - 2);
  assign wr_ptr_p1 = wr_ptr_r + 1'b1;

  assign out_chan.valid       = cnt_r != '0;
  assign out_chan.token_kind  = head.kind;
  assign out_chan.token_value = head.value;
  assign out_chan.last        = head.last;

  always_comb begin
    rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
    wr_ptr_nxt = wr_ptr_r + PTR_W'(push_n);
    cnt_nxt    = cnt_r + CNT_W'(push_n) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem_r[wr_ptr_r] <= push0;
    end
    if (push_n == 2'd2) begin
      mem_r[wr_ptr_p1] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push_n != 2'd0 |-> 32'(cnt_r) + 32'(push_n) <= 32'(FIFO_DEPTH) + 32'(pop))
    else $error("token queue overflow");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) <= 32'(FIFO_DEPTH))
    else $error("token queue count out of range");

  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == '0 |-> rd_ptr_r == wr_ptr_r)
    else $error("empty queue with pointers apart");

endmodule

// File: hw/rtl/expression_tokenizer_unit.sv
// ----------------------------------------------------------------------------
// expression_tokenizer_unit
// streaming tokenizer for expression lines: identifiers, decimal and hex
// numbers, relational pairs and single characters, one character per beat
// ----------------------------------------------------------------------------
//  channel   dir  payload                          handshake
//  in_chan   in   ch[7:0], end_of_line             valid/ready
//  out_chan  out  token_kind, token_value, last    valid/ready
//
//  one character beat per cycle while the token queue has room; a beat giving
//  two tokens takes two out beats; the input beat is registered, then scanned
//  into the 4-entry token queue, whose head drives out_chan
//  synchronous active-low reset clears the scanner and empties the queue
//  input stalls only when the token queue holds more than two tokens
// ----------------------------------------------------------------------------
module expression_tokenizer_unit import etu_pkg::*; #(
  parameter int MAX_IDENT_LEN = MAX_IDENT_LEN_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  etu_in_if.sink    in_chan,
  etu_out_if.source out_chan
);

  logic            in_vld_r, in_vld_nxt;
  logic [CH_W-1:0] ch_r;
  logic            eol_r;
  logic            in_fire;
  logic            proc_fire;
  logic            room2;
  logic [1:0]      res_n;
  logic [1:0]      push_n;
  tok_t            res0;
  tok_t            res1;

  assign proc_fire     = in_vld_r && room2;
  assign in_chan.ready = !in_vld_r || proc_fire;
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign in_vld_nxt    = in_fire || (in_vld_r && !proc_fire);
  assign push_n        = proc_fire ? res_n : 2'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      ch_r  <= in_chan.ch;
      eol_r <= in_chan.end_of_line;
    end
  end

  etu_scan #(
    .MAX_IDENT_LEN (MAX_IDENT_LEN)
  ) u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (proc_fire),
    .ch    (ch_r),
    .eol   (eol_r),
    .res_n (res_n),
    .res0  (res0),
    .res1  (res1)
  );

  etu_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_n   (push_n),
    .push0    (res0),
    .push1    (res1),
    .room2    (room2),
    .out_chan (out_chan)
  );

endmodule

// File: sim/token_stream_checker.sv
// ----------------------------------------------------------------------------
// token_stream_checker
// watches the character and token channels of the expression tokenizer,
// tokenizes every accepted character beat on its own and compares each
// token beat against the oldest predicted token
// ----------------------------------------------------------------------------
module token_stream_checker import etu_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  etu_in_if    in_chan,
  etu_out_if   out_chan,
  output int   fail_count,
  output int   tokens_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDENT_LIMIT = MAX_IDENT_LEN_DEF;

  tok_t             expected_tokens[$];
  mode_t            scan_mode;
  logic [VAL_W-1:0] number_acc;
  logic [LEN_W-1:0] ident_len;
  int               emitted;
  int               mismatches;

  assign fail_count = mismatches;

  function automatic logic is_alpha_char(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_num_char(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  // {hit, nibble}
  function automatic logic [4:0] hex_lookup(input logic [7:0] c);
    if (is_num_char(c)) return {1'b1, 4'(c - "0")};
    if (c >= "a" && c <= "f") return {1'b1, 4'(c - "a" + 8'd10)};
    if (c >= "A" && c <= "F") return {1'b1, 4'(c - "A" + 8'd10)};
    return 5'd0;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < 100) begin
      $display("%0t ns token mismatch: %s got %0h want %0h", $time, what, got, want);
    end
    mismatches++;
  endtask

  task automatic emit_token(input kind_t k, input logic [VAL_W-1:0] v);
    tok_t t;
    t.kind  = k;
    t.value = v;
    t.last  = 1'b0;
    expected_tokens.push_back(t);
    emitted++;
  endtask

  task automatic flush_pending();
    case (scan_mode)
      MODE_IDENT:         emit_token(KIND_ID, VAL_W'(ident_len));
      MODE_DEC, MODE_HEX: emit_token(KIND_INT, number_acc);
      MODE_ZERO:          emit_token(KIND_INT, '0);
      MODE_LT:            emit_token(KIND_CHAR, VAL_W'(CH_LT));
      MODE_GT:            emit_token(KIND_CHAR, VAL_W'(CH_GT));
      MODE_TILDE:         emit_token(KIND_CHAR, VAL_W'(CH_TILDE));
      default: ;
    endcase
    scan_mode = MODE_IDLE;
  endtask

  task automatic start_token(input logic [7:0] c);
    if (c == CH_SPACE || c == CH_TAB) return;
    if (is_alpha_char(c)) begin
      scan_mode = MODE_IDENT;
      ident_len = LEN_W'(1);
    end else if (c == CH_ZERO) begin
      scan_mode  = MODE_ZERO;
      number_acc = '0;
    end else if (is_num_char(c)) begin
      scan_mode  = MODE_DEC;
      number_acc = VAL_W'(c - "0");
    end else if (c == CH_LT) begin
      scan_mode = MODE_LT;
    end else if (c == CH_GT) begin
      scan_mode = MODE_GT;
    end else if (c == CH_TILDE) begin
      scan_mode = MODE_TILDE;
    end else begin
      emit_token(KIND_CHAR, VAL_W'(c));
    end
  endtask

  task automatic tokenize_char(input logic [7:0] c, input logic eol);
    logic       taken;
    logic [4:0] hx;
    tok_t       t;
    emitted = 0;
    if (eol) begin
      flush_pending();
      emit_token(KIND_EOF, '0);
    end else begin
      taken = 1'b0;
      case (scan_mode)
        MODE_IDENT: begin
          if (is_alpha_char(c) || is_num_char(c) || c == CH_UNDER) begin
            if (ident_len < IDENT_LIMIT) ident_len = ident_len + 1'b1;
            taken = 1'b1;
          end
        end
        MODE_DEC: begin
          if (is_num_char(c)) begin
            number_acc = number_acc * 32'd10 + VAL_W'(c - "0");
            taken = 1'b1;
          end
        end
        MODE_ZERO: begin
          if (c == CH_LOW_X) begin
            scan_mode  = MODE_HEX;
            number_acc = '0;
            taken = 1'b1;
          end else if (is_num_char(c)) begin
            scan_mode  = MODE_DEC;
            number_acc = VAL_W'(c - "0");
            taken = 1'b1;
          end
        end
        MODE_HEX: begin
          hx = hex_lookup(c);
          if (hx[4]) begin
            number_acc = {number_acc[VAL_W-5:0], hx[3:0]};
            taken = 1'b1;
          end
        end
        MODE_LT, MODE_GT, MODE_TILDE: begin
          if (c == CH_EQ) begin
            emit_token(scan_mode == MODE_LT ? KIND_LE :
                       scan_mode == MODE_GT ? KIND_GE : KIND_NE, '0);
            scan_mode = MODE_IDLE;
            taken = 1'b1;
          end
        end
        default: scan_mode = MODE_IDLE;
      endcase
      if (!taken) begin
        flush_pending();
        start_token(c);
      end
    end
    if (emitted > 0) begin
      t = expected_tokens.pop_back();
      t.last = 1'b1;
      expected_tokens.push_back(t);
    end
  endtask

  initial begin
    mismatches     = 0;
    tokens_pending = 0;
  end

  always @(posedge clk) begin
    tok_t want;
    if (!rst_n) begin
      scan_mode  = MODE_IDLE;
      number_acc = '0;
      ident_len  = '0;
      expected_tokens.delete();
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        tokenize_char(in_chan.ch, in_chan.end_of_line);
      end
      if (out_chan.valid && out_chan.ready) begin
        if (expected_tokens.size() == 0) begin
          report_mismatch("unexpected token beat", out_chan.token_value, '0);
        end else begin
          want = expected_tokens.pop_front();
          if (out_chan.token_kind !== want.kind) begin
            report_mismatch("token_kind", 32'(out_chan.token_kind), 32'(want.kind));
          end
          if (out_chan.token_value !== want.value) begin
            report_mismatch("token_value", out_chan.token_value, want.value);
          end
          if (out_chan.last !== want.last) begin
            report_mismatch("last", 32'(out_chan.last), 32'(want.last));
          end
        end
      end
    end
    tokens_pending <= expected_tokens.size();
  end

endmodule

// File: sim/expression_tokenizer_unit_tb.sv
// ----------------------------------------------------------------------------
// expression_tokenizer_unit_tb
// drives character beats into the expression tokenizer: a directed line
// set, then random well-formed expression lines mixed with noise, under
// three sender/receiver idling mixes, a long receiver hold-off and drains
// between phases; the token checker does the scoring
// ----------------------------------------------------------------------------
module expression_tokenizer_unit_tb import etu_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 500;

  logic       clk;
  logic       rst_n;
  int         tx_idle_pct;
  int         rx_idle_pct;
  logic       hold_start;
  int         sent_items;
  int         fail_count;
  int         tokens_pending;
  logic [8:0] line_buf[$];

  etu_in_if  in_chan();
  etu_out_if out_chan();

  expression_tokenizer_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  token_stream_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_chan       (in_chan),
    .out_chan      (out_chan),
    .fail_count    (fail_count),
    .tokens_pending(tokens_pending)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: random ready, plus a long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_start) begin
        hold_left = 400;
      end else if (hold_left != 0) begin
        hold_left--;
      end
      out_chan.ready <= !hold_start && hold_left == 0 &&
                        ($urandom_range(99) >= rx_idle_pct);
    end
  end

  initial begin
    int cycle_count;
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("expression_tokenizer_unit regression: fail");
        $finish;
      end
    end
  end

  task automatic send_beat(input logic [7:0] c, input logic eol);
    int gap;
    if ($urandom_range(99) < tx_idle_pct) begin
      gap = $urandom_range(3, 1);
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.ch          <= c;
    in_chan.end_of_line <= eol;
    @(negedge clk);
    while (!in_chan.ready) @(negedge clk);
    @(posedge clk);
    sent_items++;
  endtask

  task automatic send_line();
    foreach (line_buf[i]) send_beat(line_buf[i][7:0], line_buf[i][8]);
    line_buf.delete();
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_beat(s[i], 1'b0);
  endtask

  task automatic wait_tokens_drained();
    in_chan.valid <= 1'b0;
    @(negedge clk);
    while (tokens_pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  function automatic logic [7:0] rand_letter();
    int r;
    r = $urandom_range(51);
    return r < 26 ? 8'("a" + r) : 8'("A" + r - 26);
  endfunction

  function automatic logic [7:0] rand_hex_char();
    int r;
    r = $urandom_range(21);
    if (r < 10) return 8'("0" + r);
    if (r < 16) return 8'("a" + r - 10);
    return 8'("A" + r - 16);
  endfunction

  task automatic add_char(input logic [7:0] c);
    line_buf.push_back({1'b0, c});
  endtask

  task automatic add_ident(input int len);
    int r;
    add_char(rand_letter());
    for (int i = 1; i < len; i++) begin
      r = $urandom_range(9);
      if (r < 6) add_char(rand_letter());
      else if (r < 9) add_char(8'("0" + $urandom_range(9)));
      else add_char(CH_UNDER);
    end
  endtask

  task automatic add_decimal();
    int len;
    len = $urandom_range(12, 1);
    add_char(8'("0" + $urandom_range(9, 1)));
    for (int i = 1; i < len; i++) add_char(8'("0" + $urandom_range(9)));
  endtask

  task automatic add_zero_number();
    int len;
    add_char(CH_ZERO);
    case ($urandom_range(4))
      0, 1: begin
        add_char(CH_LOW_X);
        len = $urandom_range(10);
        for (int i = 0; i < len; i++) add_char(rand_hex_char());
      end
      2: add_char("X");
      3: begin
        len = $urandom_range(4, 1);
        for (int i = 0; i < len; i++) add_char(8'("0" + $urandom_range(9)));
      end
      default: ;
    endcase
  endtask

  task automatic add_relational();
    int r;
    r = $urandom_range(2);
    add_char(r == 0 ? CH_LT : r == 1 ? CH_GT : CH_TILDE);
    r = $urandom_range(19);
    if (r < 14) begin
      add_char(CH_EQ);
    end else if (r < 17) begin
      add_char($urandom_range(1) ? CH_SPACE : CH_TAB);
      add_char(CH_EQ);
    end
  endtask

  task automatic add_single();
    string ops;
    ops = "+-*/()=,;!&|^%[]{}.:?@#$_";
    if ($urandom_range(3) == 0) add_char(8'($urandom));
    else add_char(ops[$urandom_range(ops.len() - 1)]);
  endtask

  task automatic build_line();
    int n;
    int sep;
    n = $urandom_range(6, 1);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(5))
        0: add_ident($urandom_range(39) == 0 ? $urandom_range(130, 75)
                                             : $urandom_range(8, 1));
        1: add_decimal();
        2: add_zero_number();
        3: add_relational();
        default: add_single();
      endcase
      sep = $urandom_range(4);
      for (int j = 0; j < sep - 2; j++) add_char($urandom_range(1) ? CH_SPACE : CH_TAB);
    end
    if ($urandom_range(9) != 0) line_buf.push_back({1'b1, 8'($urandom)});
  endtask

  task automatic build_noise();
    int n;
    n = $urandom_range(8, 1);
    for (int i = 0; i < n; i++) line_buf.push_back({$urandom_range(7) == 0, 8'($urandom)});
  endtask

  task automatic run_random(input int target);
    while (sent_items < target) begin
      if ($urandom_range(99) < 85) build_line();
      else build_noise();
      send_line();
    end
  endtask

  initial begin
    rst_n               <= 1'b0;
    in_chan.valid       <= 1'b0;
    in_chan.ch          <= '0;
    in_chan.end_of_line <= 1'b0;
    hold_start          <= 1'b0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    sent_items  = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: hex, upper X, relationals, split relational, tab,
    // zero and all-ones codes, empty hex run, underscore after a number
    send_text("0x+0X9<=>=~=< =\t");
    send_beat(8'h00, 1'b1);
    send_beat(8'h00, 1'b0);
    send_beat(8'hff, 1'b0);
    send_text("0x");
    send_beat(8'hff, 1'b1);
    send_text("8_");
    send_beat(8'h00, 1'b1);
    wait_tokens_drained();

    tx_idle_pct = 25;
    rx_idle_pct = 62;
    add_ident(100);
    line_buf.push_back({1'b1, 8'h5a});
    send_line();
    run_random(sent_items + PHASE_ITEMS);
    wait_tokens_drained();

    tx_idle_pct = 62;
    rx_idle_pct = 25;
    run_random(sent_items + PHASE_ITEMS);
    wait_tokens_drained();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_start <= 1'b1;
    @(posedge clk);
    hold_start <= 1'b0;
    run_random(sent_items + PHASE_ITEMS);

    wait_tokens_drained();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("expression_tokenizer_unit regression: pass");
    end else begin
      $display("expression_tokenizer_unit regression: fail");
    end
    $finish;
  end

endmodule
